[design/crcfr_pkg.sv]
// Shared types, codes and constants of the CRC checked frame receiver.
package crcfr_pkg;

    // Default payload buffer size in bytes
    localparam int unsigned MAX_PAYLOAD_DEF = 256;

    // Store address field wide enough for the largest legal buffer
    localparam int unsigned ADDR_W = 16;

    // Depth of the word queue between parser and store
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_HEAD_FIRST  = 2'd0;
    localparam logic [1:0] CFG_HEAD_SECOND = 2'd1;
    localparam logic [1:0] CFG_TAIL_FIRST  = 2'd2;
    localparam logic [1:0] CFG_TAIL_SECOND = 2'd3;

    localparam logic [7:0] HEAD_FIRST_RST  = 8'hA5;
    localparam logic [7:0] HEAD_SECOND_RST = 8'h06;
    localparam logic [7:0] TAIL_FIRST_RST  = 8'hB6;
    localparam logic [7:0] TAIL_SECOND_RST = 8'h07;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Discovery string, reported as a probe instead of a delivery
    localparam int unsigned PROBE_LEN = 21;
    localparam int unsigned PROBE_IW  = $clog2(PROBE_LEN);
    localparam logic [7:0] PROBE_TEXT [PROBE_LEN] = '{
        8'h5B, 8'h41, 8'h72, 8'h65, 8'h20, 8'h79, 8'h6F, 8'h75, 8'h20, 8'h61, 8'h6E,
        8'h20, 8'h65, 8'h6D, 8'h75, 8'h61, 8'h72, 8'h74, 8'h3F, 8'h3F, 8'h5D
    };

    typedef enum logic [2:0] {
        ST_ABSORBED  = 3'd0,
        ST_HEAD_BAD  = 3'd1,
        ST_GOOD      = 3'd2,
        ST_CHECK_BAD = 3'd3,
        ST_PROBE     = 3'd4,
        ST_LEN_BAD   = 3'd5
    } status_t;

    // One word of work for the store side
    typedef struct packed {
        logic              rd_en;   // read inside the buffer
        logic              wr_en;   // payload byte to store
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
        status_t           status;
        logic [8:0]        plen;
    } queue_entry_t;

    // CRC-16/MODBUS update by one byte, reflected
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

[design/crcfr_front.sv]
// Frame parser: takes words, tracks frame position, checks CRC and tail.
module crcfr_front #(
    parameter int unsigned MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [15:0]            s_tdata,
    input  logic                   s_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [7:0]             cfg_data,
    output logic                   push_valid,
    input  logic                   push_ready,
    output crcfr_pkg::queue_entry_t push_entry
);
    import crcfr_pkg::*;

    localparam int unsigned PW      = $clog2(MAX_PAYLOAD + 8);
    localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

    logic [7:0]    head0_reg, head1_reg, tail0_reg, tail1_reg;
    logic [PW-1:0] pos_reg, pos_next;
    logic [15:0]   len_reg, len_next;
    logic [15:0]   crc_reg, crc_next;
    logic [23:0]   trl_reg, trl_next;
    logic          probe_reg, probe_next;

    logic                accept;
    logic [7:0]          rx_b;
    logic [7:0]          ridx;
    logic [16:0]         pos_ext;
    logic [16:0]         len_ext;
    logic [15:0]         len_full;
    logic [ADDR_W-1:0]   pay_addr;
    logic [PROBE_IW-1:0] probe_idx;
    logic                probe_hit;
    logic                frame_ok;

    assign rx_b      = s_tdata[7:0];
    assign ridx      = s_tdata[15:8];
    assign s_tready  = push_ready;
    assign push_valid = s_tvalid;
    assign accept    = s_tvalid && push_ready;
    assign cfg_ready = 1'b1;

    assign pos_ext   = 17'(pos_reg);
    assign len_ext   = {1'b0, len_reg};
    assign len_full  = {len_reg[15:8], rx_b};
    assign pay_addr  = ADDR_W'(pos_ext - 17'd4);
    assign probe_idx = (pay_addr < ADDR_W'(PROBE_LEN)) ? pay_addr[PROBE_IW-1:0] : '0;
    assign probe_hit = (pay_addr < ADDR_W'(PROBE_LEN)) && (PROBE_TEXT[probe_idx] == rx_b);
    assign frame_ok  = (trl_reg[23:16] == crc_reg[15:8]) && (trl_reg[15:8] == crc_reg[7:0])
                       && (trl_reg[7:0] == tail0_reg) && (rx_b == tail1_reg);

    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        trl_next   = trl_reg;
        probe_next = probe_reg;

        push_entry.rd_en  = s_tuser && ({9'd0, ridx} < MAX_LEN);
        push_entry.wr_en  = 1'b0;
        push_entry.addr   = s_tuser ? {{(ADDR_W-8){1'b0}}, ridx} : pay_addr;
        push_entry.wdata  = rx_b;
        push_entry.status = ST_ABSORBED;
        push_entry.plen   = '0;

        if (!s_tuser) begin
            if (pos_reg == PW'(0)) begin
                if (rx_b == head0_reg) begin
                    pos_next = PW'(1);
                    len_next = '0;
                    crc_next = CRC_INIT;
                    trl_next = '0;
                    probe_next = 1'b1;
                end else begin
                    push_entry.status = ST_HEAD_BAD;
                end
            end else if (pos_reg == PW'(1)) begin
                if (rx_b == head1_reg) begin
                    pos_next = PW'(2);
                end else begin
                    pos_next = '0;
                    len_next = '0;
                    crc_next = CRC_INIT;
                    trl_next = '0;
                    probe_next = 1'b1;
                    push_entry.status = ST_HEAD_BAD;
                end
            end else if (pos_reg == PW'(2)) begin
                len_next = {rx_b, 8'h00};
                pos_next = PW'(3);
            end else if (pos_reg == PW'(3)) begin
                if (len_full == 16'd0 || {1'b0, len_full} > MAX_LEN) begin
                    pos_next = '0;
                    len_next = '0;
                    crc_next = CRC_INIT;
                    trl_next = '0;
                    probe_next = 1'b1;
                    push_entry.status = ST_LEN_BAD;
                end else begin
                    len_next = len_full;
                    pos_next = PW'(4);
                end
            end else if (pos_ext < len_ext + 17'd4) begin
                // payload byte: store it, fold into CRC, track the probe text
                push_entry.wr_en = 1'b1;
                crc_next = crc16_byte(crc_reg, rx_b);
                if (!probe_hit)
                    probe_next = 1'b0;
                pos_next = pos_reg + PW'(1);
            end else if (pos_ext < len_ext + 17'd7) begin
                trl_next = {trl_reg[15:0], rx_b};
                pos_next = pos_reg + PW'(1);
            end else begin
                if (frame_ok) begin
                    if (len_reg == 16'(PROBE_LEN) && probe_reg) begin
                        push_entry.status = ST_PROBE;
                    end else begin
                        push_entry.status = ST_GOOD;
                        push_entry.plen   = len_reg[8:0];
                    end
                end else begin
                    push_entry.status = ST_CHECK_BAD;
                end
                pos_next = '0;
                len_next = '0;
                crc_next = CRC_INIT;
                trl_next = '0;
                probe_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= '0;
            len_reg   <= '0;
            crc_reg   <= CRC_INIT;
            trl_reg   <= '0;
            probe_reg <= 1'b1;
        end else if (accept) begin
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            trl_reg   <= trl_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head0_reg <= HEAD_FIRST_RST;
            head1_reg <= HEAD_SECOND_RST;
            tail0_reg <= TAIL_FIRST_RST;
            tail1_reg <= TAIL_SECOND_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_HEAD_FIRST:  head0_reg <= cfg_data;
                CFG_HEAD_SECOND: head1_reg <= cfg_data;
                CFG_TAIL_FIRST:  tail0_reg <= cfg_data;
                CFG_TAIL_SECOND: tail1_reg <= cfg_data;
                default:         head0_reg <= head0_reg;
            endcase
        end
    end

endmodule

[design/crcfr_queue.sv]
// Short word queue between the frame parser and the store side.
module crcfr_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  crcfr_pkg::queue_entry_t push_entry,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output crcfr_pkg::queue_entry_t pop_entry
);
    import crcfr_pkg::*;

    queue_entry_t      slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[design/crcfr_back.sv]
// Store side: payload buffer writes and reads in word order, result register.
module crcfr_back #(
    parameter int unsigned MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  crcfr_pkg::queue_entry_t pop_entry,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata
);
    import crcfr_pkg::*;

    localparam int unsigned AW = $clog2(MAX_PAYLOAD);

    logic [7:0] store_mem [MAX_PAYLOAD];

    logic       out_valid_reg, out_valid_next;
    status_t    status_reg;
    logic [8:0] plen_reg;
    logic       rd_en_reg;
    logic [7:0] rd_data_reg;
    logic       advance;
    logic       pop_fire;
    logic [AW-1:0] mem_addr;
    logic [7:0] read_data;

    assign advance   = !out_valid_reg || m_tready;
    assign pop_ready = advance;
    assign pop_fire  = pop_valid && advance;
    assign mem_addr  = pop_entry.addr[AW-1:0];
    assign out_valid_next = advance ? pop_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire) begin
            if (pop_entry.wr_en)
                store_mem[mem_addr] <= pop_entry.wdata;
            rd_data_reg <= store_mem[mem_addr];
            status_reg  <= pop_entry.status;
            plen_reg    <= pop_entry.plen;
            rd_en_reg   <= pop_entry.rd_en;
        end
    end

    assign read_data = rd_en_reg ? rd_data_reg : 8'h00;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'h0, read_data, plen_reg, status_reg};

endmodule

[design/crc_checked_frame_receiver_top.sv]
// Top level of the CRC checked frame receiver.
//
// Input stream (s_*): one word per received UART byte or per buffer read.
// s_tuser = 0 carries a received byte in s_tdata[7:0]; s_tuser = 1 asks
// for the stored payload byte at s_tdata[15:8]. Frames are two head bytes,
// a big-endian length, the payload, a big-endian CRC-16/MODBUS of the
// payload and two tail bytes. Every input word gives exactly one result.
// Output stream (m_*): status, payload length of a good frame and the read
// byte (zero unless the word was an in-range read).
// Configuration channel (cfg_*): writes head and tail bytes by index; it is
// always ready and is meant to be used while no words are in flight.
// A result passes through the queue and the result register before it shows
// on m_tvalid. Throughput: one word per cycle while the queue is not full;
// the parser updates its frame state for each byte and the buffer takes one
// access per cycle while the result register can advance.
// Stall: a four-word queue and the result register absorb a stalled
// receiver; s_tready drops once the queue is full.
// Reset: head/tail bytes return to defaults, the parser hunts for a head,
// the queue and result register empty; buffer contents stay undefined.
module crc_checked_frame_receiver_top #(
    parameter int unsigned MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] read_index
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] status, [11:3] payload_length,
                                   // [19:12] read_data, [23:20] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import crcfr_pkg::*;

    queue_entry_t push_entry, pop_entry;
    logic         push_valid, push_ready;
    logic         pop_valid, pop_ready;

    // Parse and classify each word
    crcfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Decouple parser from store side
    crcfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Apply buffer accesses in order and hold the result
    crcfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[design/crcfr_checker.sv]
// Port-level checker for the frame receiver, bound to the top level.
module crcfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [7:0]  cfg_data
);
    import crcfr_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // Only a good frame reports a length
    a_len_only_good: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] != ST_GOOD |-> m_tdata[11:3] == 9'd0)
        else $error("payload length without good frame");

    // Read data comes only with an absorbed status
    a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[19:12] != 8'd0 |-> m_tdata[2:0] == ST_ABSORBED)
        else $error("read data with frame status");

    // No result right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

    // A result needs an earlier input word
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid, 2) || $past(s_tvalid, 1)
                            || $past(m_tvalid, 1))
        else $error("result without input word");

endmodule

bind crc_checked_frame_receiver_top crcfr_checker u_checker (.*);

[bench/tb_top.sv]
// Self-checking bench for the CRC checked frame receiver: frames, reads, register writes.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crcfr_pkg::*;

    localparam int unsigned BUF_BYTES   = MAX_PAYLOAD_DEF;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 6;

    typedef logic [7:0] byte_q_t [$];

    typedef enum int {
        FAULT_NONE,
        FAULT_HEAD_SECOND,
        FAULT_CRC_HI,
        FAULT_CRC_LO,
        FAULT_TAIL_FIRST,
        FAULT_TAIL_SECOND,
        FAULT_TRUNCATED
    } frame_fault_t;

    // What the receiver must answer for one word
    typedef struct packed {
        status_t    status;
        logic [8:0] plen;
        logic [7:0] rdata;
    } rx_verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // [7:0] rx_byte, [15:8] read_index
    logic        s_tuser = 1'b0;   // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [2:0] status, [11:3] payload_length,
                                   // [19:12] read_data, [23:20] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_HEAD_FIRST;
    logic [7:0]  cfg_data = '0;

    // Deframer state as the bench predicts it
    logic [7:0]  hdr1_byte, hdr2_byte, trl1_byte, trl2_byte;
    logic [8:0]  fpos;
    logic [15:0] dlen;
    logic [15:0] crc_acc;
    logic [23:0] trail;
    bit          probe_match;
    logic [7:0]  payload_mem [BUF_BYTES];
    bit          payload_seen [BUF_BYTES];

    rx_verdict_t verdict_q [$];
    int unsigned words_sent = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned src_idle_pct = 37;
    int unsigned snk_idle_pct = 50;

    crc_checked_frame_receiver_top #(
        .MAX_PAYLOAD (BUF_BYTES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [15:0] modbus_crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function void restart_hunt();
        fpos        = '0;
        dlen        = '0;
        crc_acc     = CRC_INIT;
        trail       = '0;
        probe_match = 1'b1;
    endfunction

    function void apply_reg(input logic [1:0] idx, input logic [7:0] val);
        case (idx)
            CFG_HEAD_FIRST:  hdr1_byte = val;
            CFG_HEAD_SECOND: hdr2_byte = val;
            CFG_TAIL_FIRST:  trl1_byte = val;
            default:         trl2_byte = val;
        endcase
    endfunction

    // Advance the predicted deframer by one accepted word
    function automatic rx_verdict_t deframe_predict(input logic mode, input logic [7:0] b,
                                                    input logic [7:0] idx);
        rx_verdict_t v;
        int unsigned p;
        v.status = ST_ABSORBED;
        v.plen   = '0;
        v.rdata  = '0;
        if (mode) begin
            if (int'(idx) < BUF_BYTES)
                v.rdata = payload_mem[idx];
        end else if (fpos == 9'd0) begin
            if (b == hdr1_byte) begin
                restart_hunt();
                fpos = 9'd1;
            end else begin
                v.status = ST_HEAD_BAD;
            end
        end else if (fpos == 9'd1) begin
            // a wrong second byte drops back to the hunt, not retried as a first byte
            if (b == hdr2_byte) begin
                fpos = 9'd2;
            end else begin
                restart_hunt();
                v.status = ST_HEAD_BAD;
            end
        end else if (fpos == 9'd2) begin
            dlen = {b, 8'h00};
            fpos = 9'd3;
        end else if (fpos == 9'd3) begin
            dlen[7:0] = b;
            if (dlen == 16'd0 || int'(dlen) > BUF_BYTES) begin
                restart_hunt();
                v.status = ST_LEN_BAD;
            end else begin
                fpos = 9'd4;
            end
        end else if (int'(fpos) < int'(dlen) + 4) begin
            // payload lands in the store right away, even if the frame is later dropped
            p = int'(fpos) - 4;
            payload_mem[p]  = b;
            payload_seen[p] = 1'b1;
            crc_acc = modbus_crc_next(crc_acc, b);
            if (p >= PROBE_LEN)
                probe_match = 1'b0;
            else if (PROBE_TEXT[p] != b)
                probe_match = 1'b0;
            fpos = fpos + 9'd1;
        end else if (int'(fpos) < int'(dlen) + 7) begin
            trail = {trail[15:0], b};
            fpos  = fpos + 9'd1;
        end else begin
            if (trail[23:8] == crc_acc && trail[7:0] == trl1_byte && b == trl2_byte) begin
                if (int'(dlen) == PROBE_LEN && probe_match) begin
                    v.status = ST_PROBE;
                end else begin
                    v.status = ST_GOOD;
                    v.plen   = dlen[8:0];
                end
            end else begin
                v.status = ST_CHECK_BAD;
            end
            restart_hunt();
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Sink stalls at random at the current rate
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        rx_verdict_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected result word", 32'(m_tdata), 0);
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[2:0] != want.status)
                    report_mismatch("status", 32'(m_tdata[2:0]), 32'(want.status));
                if (m_tdata[11:3] != want.plen)
                    report_mismatch("payload_length", 32'(m_tdata[11:3]), 32'(want.plen));
                if (m_tdata[19:12] != want.rdata)
                    report_mismatch("read_data", 32'(m_tdata[19:12]), 32'(want.rdata));
                if (m_tdata[23:20] != 4'd0)
                    report_mismatch("pad bits", 32'(m_tdata[23:20]), 0);
            end
        end
    end

    // Stop a hung run: count cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; every task starts and ends at a falling edge
    // ------------------------------------------------------------------

    task automatic send_word(input logic mode, input logic [7:0] rx, input logic [7:0] idx);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {idx, rx};
        do @(posedge clk); while (!s_tready);
        verdict_q.push_back(deframe_predict(mode, rx, idx));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(1'b0, b, 8'($urandom()));
    endtask

    // Read some store entry that has been written; skip while none is
    task automatic send_read();
        int unsigned start;
        start = $urandom_range(BUF_BYTES - 1);
        for (int unsigned k = 0; k < BUF_BYTES; k++) begin
            if (payload_seen[(start + k) % BUF_BYTES]) begin
                send_word(1'b1, 8'($urandom()), 8'((start + k) % BUF_BYTES));
                return;
            end
        end
    endtask

    // Hold the input low until every predicted word has come back
    task automatic await_drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (verdict_q.size() != 0);
    endtask

    task automatic write_regs(input logic [7:0] h1, input logic [7:0] h2,
                              input logic [7:0] t1, input logic [7:0] t2);
        logic [1:0] idx [4];
        logic [7:0] val [4];
        idx = '{CFG_HEAD_FIRST, CFG_HEAD_SECOND, CFG_TAIL_FIRST, CFG_TAIL_SECOND};
        val = '{h1, h2, t1, t2};
        await_drain();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            apply_reg(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic byte_q_t random_body(input int unsigned n);
        byte_q_t q;
        repeat (n) q.push_back(8'($urandom()));
        return q;
    endfunction

    function automatic byte_q_t probe_body();
        byte_q_t q;
        foreach (PROBE_TEXT[i]) q.push_back(PROBE_TEXT[i]);
        return q;
    endfunction

    // Mostly short payloads, now and then a full buffer
    function automatic int unsigned draw_length();
        if ($urandom_range(39) == 0)
            return BUF_BYTES;
        return $urandom_range(24, 1);
    endfunction

    function automatic logic [15:0] bad_length();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'(BUF_BYTES + 1);
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(65535, BUF_BYTES + 1));
        endcase
    endfunction

    // Build head, length, payload, CRC and tail with the current registers,
    // corrupt one spot or cut the frame short if asked, and send it with a few reads mixed in
    task automatic send_frame(input byte_q_t body, input frame_fault_t fault);
        byte_q_t     wire_q;
        logic [15:0] crc;
        logic [7:0]  flip;
        int unsigned n;
        int unsigned keep;
        n    = body.size();
        crc  = CRC_INIT;
        flip = 8'($urandom_range(255, 1));
        foreach (body[i]) crc = modbus_crc_next(crc, body[i]);
        wire_q.push_back(hdr1_byte);
        wire_q.push_back(hdr2_byte);
        wire_q.push_back(8'(n >> 8));
        wire_q.push_back(8'(n));
        foreach (body[i]) wire_q.push_back(body[i]);
        wire_q.push_back(crc[15:8]);
        wire_q.push_back(crc[7:0]);
        wire_q.push_back(trl1_byte);
        wire_q.push_back(trl2_byte);
        keep = wire_q.size();
        case (fault)
            FAULT_HEAD_SECOND: wire_q[1]     ^= flip;
            FAULT_CRC_HI:      wire_q[4 + n] ^= flip;
            FAULT_CRC_LO:      wire_q[5 + n] ^= flip;
            FAULT_TAIL_FIRST:  wire_q[6 + n] ^= flip;
            FAULT_TAIL_SECOND: wire_q[7 + n] ^= flip;
            FAULT_TRUNCATED:   keep = $urandom_range(wire_q.size() - 1, 1);
            default: ;
        endcase
        for (int unsigned i = 0; i < keep; i++) begin
            if ($urandom_range(15) == 0)
                send_read();
            send_byte(wire_q[i]);
        end
    endtask

    task automatic send_bad_length(input logic [15:0] len);
        send_byte(hdr1_byte);
        send_byte(hdr2_byte);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hunt, head mismatches, bad lengths, then the smallest good frame
    task automatic test_head_and_length();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(hdr1_byte);
        send_byte(hdr1_byte);
        send_byte(hdr2_byte);
        send_bad_length(16'h0000);
        send_bad_length(16'(BUF_BYTES + 1));
        send_bad_length(16'hFFFF);
        send_frame(random_body(1), FAULT_NONE);
        send_word(1'b1, 8'hFF, 8'h00);
    endtask

    // Discovery string, and near misses that must deliver as normal frames
    task automatic test_probe();
        byte_q_t body;
        send_frame(probe_body(), FAULT_NONE);
        body = probe_body();
        body[20] ^= 8'h01;
        send_frame(body, FAULT_NONE);
        body = probe_body();
        body.push_back(8'h00);
        send_frame(body, FAULT_NONE);
        send_word(1'b1, 8'h00, 8'd0);
        send_word(1'b1, 8'h00, 8'd20);
    endtask

    task automatic test_bad_trailer();
        send_frame(random_body(2), FAULT_CRC_HI);
        send_frame(random_body(2), FAULT_CRC_LO);
        send_frame(random_body(2), FAULT_TAIL_FIRST);
        send_frame(random_body(2), FAULT_TAIL_SECOND);
        send_frame(random_body(2), FAULT_HEAD_SECOND);
    endtask

    // Fill the whole store, read its corners, then overwrite with a dropped frame
    task automatic test_full_buffer();
        send_frame(random_body(BUF_BYTES), FAULT_NONE);
        send_word(1'b1, 8'h00, 8'h00);
        send_word(1'b1, 8'hFF, 8'hFF);
        send_word(1'b1, 8'h00, 8'h55);
        send_word(1'b1, 8'hFF, 8'hAA);
        send_frame(random_body(BUF_BYTES), FAULT_CRC_LO);
        send_word(1'b1, 8'h00, 8'h00);
        send_word(1'b1, 8'h00, 8'hFF);
        send_frame(random_body(3), FAULT_NONE);
        for (int i = 0; i < 4; i++)
            send_word(1'b1, 8'($urandom()), 8'(i));
    endtask

    task automatic test_register_extremes();
        write_regs(8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(random_body(4), FAULT_NONE);
        send_frame(random_body(4), FAULT_TAIL_SECOND);
        send_byte(8'h01);
        write_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_frame(random_body(5), FAULT_NONE);
        send_bad_length(16'(BUF_BYTES + 1));
        send_byte(8'h00);
        await_drain();
    endtask

    // Mostly well-formed frames with random content; the rest broken or noise
    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                       input int unsigned quota);
        int unsigned stop_at;
        int unsigned pick;
        byte_q_t     body;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at = words_sent + quota;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                send_frame(random_body(draw_length()), FAULT_NONE);
            end else if (pick < 55) begin
                send_frame(probe_body(), FAULT_NONE);
            end else if (pick < 59) begin
                body = probe_body();
                if ($urandom_range(1) == 0)
                    body.push_back(8'($urandom()));
                else
                    body[$urandom_range(PROBE_LEN - 1)] ^= 8'($urandom_range(255, 1));
                send_frame(body, FAULT_NONE);
            end else if (pick < 67) begin
                send_frame(random_body(draw_length()),
                           frame_fault_t'($urandom_range(int'(FAULT_TAIL_SECOND),
                                                         int'(FAULT_CRC_HI))));
            end else if (pick < 71) begin
                send_frame(random_body(draw_length()), FAULT_HEAD_SECOND);
            end else if (pick < 76) begin
                send_bad_length(bad_length());
            end else if (pick < 82) begin
                repeat ($urandom_range(3, 1)) send_byte(8'($urandom()));
            end else if (pick < 86) begin
                send_frame(random_body(draw_length()), FAULT_TRUNCATED);
            end else begin
                repeat ($urandom_range(4, 1)) send_read();
            end
            if ($urandom_range(9) == 0)
                await_drain();
        end
        await_drain();
    endtask

    initial
    begin
        hdr1_byte = HEAD_FIRST_RST;
        hdr2_byte = HEAD_SECOND_RST;
        trl1_byte = TAIL_FIRST_RST;
        trl2_byte = TAIL_SECOND_RST;
        restart_hunt();
        foreach (payload_seen[i]) payload_seen[i] = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_head_and_length();
        test_probe();
        test_bad_trailer();
        test_full_buffer();
        test_register_extremes();

        write_regs(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
        test_random_traffic(37, 50, 80);
        write_regs(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
        test_random_traffic(50, 37, 80);
        write_regs(HEAD_FIRST_RST, HEAD_SECOND_RST, TAIL_FIRST_RST, TAIL_SECOND_RST);
        test_random_traffic(0, 0, 80);

        await_drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
